// ----- rtl/core/tbi_pkg.sv -----
// Types and constants shared by the triangle test and interpolation block.
package tbi_pkg;

    localparam int K_CW      = 16;          // coordinate width, Q12.4
    localparam int K_DW      = K_CW + 1;    // vertex difference width
    localparam int K_VW      = 19;          // doubled projected edge vector width
    localparam int K_PW      = 2 * K_VW;    // edge product width
    localparam int K_XW      = 40;          // cross product width
    localparam int K_HW      = 20;          // low part of a split cross product
    localparam int K_MW      = 38;          // partial product width
    localparam int K_NW      = 60;          // interpolation numerator width
    localparam int K_QW      = 17;          // quotient bits produced by the divider
    localparam int K_DENW    = K_XW - 1;    // denominator magnitude width

    localparam int K_FRONT_LAT = 5;
    localparam int K_DIV_LAT   = K_QW + 4;
    localparam int K_BACK_LAT  = 3 + K_DIV_LAT;

    localparam logic [K_QW-1:0] K_QMAX_POS = K_QW'(32767);
    localparam logic [K_QW-1:0] K_QMAX_NEG = K_QW'(32768);

    typedef struct packed {
        logic signed [K_CW-1:0] pixel_x;
        logic signed [K_CW-1:0] pixel_y;
        logic signed [K_CW-1:0] vertex_a_x;
        logic signed [K_CW-1:0] vertex_a_y;
        logic signed [K_CW-1:0] vertex_a_z;
        logic signed [K_CW-1:0] vertex_b_x;
        logic signed [K_CW-1:0] vertex_b_y;
        logic signed [K_CW-1:0] vertex_b_z;
        logic signed [K_CW-1:0] vertex_c_x;
        logic signed [K_CW-1:0] vertex_c_y;
        logic signed [K_CW-1:0] vertex_c_z;
    } t_in;

    typedef struct packed {
        logic                   inside_res;
        logic                   degenerate;
        logic signed [K_CW-1:0] surface_x;
        logic signed [K_CW-1:0] surface_y;
        logic signed [K_CW-1:0] surface_z;
    } t_out;

    // one 3D axis: vertex A and the offsets of B and C from it
    typedef struct packed {
        logic signed [K_CW-1:0] a;
        logic signed [K_DW-1:0] ba;
        logic signed [K_DW-1:0] ca;
    } t_coord;

    typedef struct packed {
        logic                   in_tri;
        logic                   degenerate;
    } t_flags;

    // classified item handed from front to back
    typedef struct packed {
        t_flags                 flags;
        logic signed [K_XW-1:0] det;
        logic signed [K_XW-1:0] nb;
        logic signed [K_XW-1:0] nc;
        t_coord [2:0]           crd;
    } t_mid;

endpackage

// ----- rtl/core/tbi_fifo.sv -----
// Small first-in first-out queue with show-ahead read.
module tbi_fifo import tbi_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_wr) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_rd) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);

endmodule

// ----- rtl/core/tbi_front.sv -----
// Front pipeline: oblique projection, cross products and inside classification.
module tbi_front import tbi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_in  i_item,
    output logic o_vld,
    output t_mid o_mid
);
    localparam int PJW = K_CW + 2;

    logic [K_FRONT_LAT-1:0] r_vld;

    // projected coordinates held doubled so that the halving stays exact
    function automatic logic signed [PJW-1:0] proj_x(logic signed [K_CW-1:0] x,
                                                     logic signed [K_CW-1:0] y);
        return (PJW'(x) + PJW'(y)) <<< 1;
    endfunction

    function automatic logic signed [PJW-1:0] proj_y(logic signed [K_CW-1:0] x,
                                                     logic signed [K_CW-1:0] y,
                                                     logic signed [K_CW-1:0] z);
        return (PJW'(z) <<< 1) + PJW'(y) - PJW'(x);
    endfunction

    logic signed [PJW-1:0] a2x, a2y, b2x, b2y, c2x, c2y, p2x, p2y;

    always_comb begin
        a2x = proj_x(i_item.vertex_a_x, i_item.vertex_a_y);
        a2y = proj_y(i_item.vertex_a_x, i_item.vertex_a_y, i_item.vertex_a_z);
        b2x = proj_x(i_item.vertex_b_x, i_item.vertex_b_y);
        b2y = proj_y(i_item.vertex_b_x, i_item.vertex_b_y, i_item.vertex_b_z);
        c2x = proj_x(i_item.vertex_c_x, i_item.vertex_c_y);
        c2y = proj_y(i_item.vertex_c_x, i_item.vertex_c_y, i_item.vertex_c_z);
        p2x = PJW'(i_item.pixel_x) <<< 1;
        p2y = PJW'(i_item.pixel_y) <<< 1;
    end

    // stage 1: edge vectors
    logic signed [K_VW-1:0] r1_v0x, r1_v0y, r1_v1x, r1_v1y, r1_v2x, r1_v2y;
    t_coord [2:0]           r1_crd, r2_crd, r3_crd, r4_crd;

    always_ff @(posedge i_clk) begin
        r1_v0x <= K_VW'(c2x) - K_VW'(a2x);
        r1_v0y <= K_VW'(c2y) - K_VW'(a2y);
        r1_v1x <= K_VW'(b2x) - K_VW'(a2x);
        r1_v1y <= K_VW'(b2y) - K_VW'(a2y);
        r1_v2x <= K_VW'(p2x) - K_VW'(a2x);
        r1_v2y <= K_VW'(p2y) - K_VW'(a2y);
        r1_crd[0].a  <= i_item.vertex_a_x;
        r1_crd[0].ba <= K_DW'(i_item.vertex_b_x) - K_DW'(i_item.vertex_a_x);
        r1_crd[0].ca <= K_DW'(i_item.vertex_c_x) - K_DW'(i_item.vertex_a_x);
        r1_crd[1].a  <= i_item.vertex_a_y;
        r1_crd[1].ba <= K_DW'(i_item.vertex_b_y) - K_DW'(i_item.vertex_a_y);
        r1_crd[1].ca <= K_DW'(i_item.vertex_c_y) - K_DW'(i_item.vertex_a_y);
        r1_crd[2].a  <= i_item.vertex_a_z;
        r1_crd[2].ba <= K_DW'(i_item.vertex_b_z) - K_DW'(i_item.vertex_a_z);
        r1_crd[2].ca <= K_DW'(i_item.vertex_c_z) - K_DW'(i_item.vertex_a_z);
    end

    // stage 2: products of the three cross products
    logic signed [K_PW-1:0] r2_p0, r2_p1, r2_p2, r2_p3, r2_p4, r2_p5;

    always_ff @(posedge i_clk) begin
        r2_p0  <= K_PW'(r1_v0x) * K_PW'(r1_v1y);
        r2_p1  <= K_PW'(r1_v0y) * K_PW'(r1_v1x);
        r2_p2  <= K_PW'(r1_v2x) * K_PW'(r1_v1y);
        r2_p3  <= K_PW'(r1_v2y) * K_PW'(r1_v1x);
        r2_p4  <= K_PW'(r1_v0x) * K_PW'(r1_v2y);
        r2_p5  <= K_PW'(r1_v0y) * K_PW'(r1_v2x);
        r2_crd <= r1_crd;
    end

    // stage 3: det, nc, nb
    logic signed [K_XW-1:0] r3_det, r3_nc, r3_nb;

    always_ff @(posedge i_clk) begin
        r3_det <= K_XW'(r2_p0) - K_XW'(r2_p1);
        r3_nc  <= K_XW'(r2_p2) - K_XW'(r2_p3);
        r3_nb  <= K_XW'(r2_p4) - K_XW'(r2_p5);
        r3_crd <= r2_crd;
    end

    // stage 4: flip signs so that det is not negative
    logic signed [K_XW-1:0] r4_det, r4_nc, r4_nb;
    logic                   r4_deg;

    always_ff @(posedge i_clk) begin
        r4_deg <= (r3_det == '0);
        if (r3_det[K_XW-1]) begin
            r4_det <= -r3_det;
            r4_nc  <= -r3_nc;
            r4_nb  <= -r3_nb;
        end else begin
            r4_det <= r3_det;
            r4_nc  <= r3_nc;
            r4_nb  <= r3_nb;
        end
        r4_crd <= r3_crd;
    end

    // stage 5: exact inside test, edges included
    logic signed [K_XW:0] sum_w;
    t_mid                 r5_mid;

    assign sum_w = (K_XW + 1)'(r4_nc) + (K_XW + 1)'(r4_nb);

    always_ff @(posedge i_clk) begin
        r5_mid.flags.degenerate <= r4_deg;
        r5_mid.flags.in_tri     <= !r4_deg && !r4_nc[K_XW-1] && !r4_nb[K_XW-1]
                                   && (sum_w <= (K_XW + 1)'(r4_det));
        r5_mid.det <= r4_det;
        r5_mid.nb  <= r4_nb;
        r5_mid.nc  <= r4_nc;
        r5_mid.crd <= r4_crd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[K_FRONT_LAT-2:0], i_vld};
        end
    end

    assign o_vld = r_vld[K_FRONT_LAT-1];
    assign o_mid = r5_mid;

endmodule

// ----- rtl/core/tbi_div.sv -----
// Pipelined restoring divider: rounded, saturated 16-bit quotient of num by den.
module tbi_div import tbi_pkg::*; (
    input  logic                   i_clk,
    input  logic signed [K_NW-1:0] i_num,
    input  logic [K_DENW-1:0]      i_den,
    output logic signed [K_CW-1:0] o_quo
);
    // D0: magnitude and sign
    logic [K_NW-1:0]   r0_abs;
    logic [K_DENW-1:0] r0_den;
    logic              r0_neg;

    always_ff @(posedge i_clk) begin
        r0_neg <= i_num[K_NW-1];
        r0_abs <= i_num[K_NW-1] ? K_NW'(-i_num) : K_NW'(i_num);
        r0_den <= i_den;
    end

    // D1: add half the denominator for round to nearest, ties away from zero
    logic [K_NW-1:0]   r1_mag;
    logic [K_DENW-1:0] r1_den;
    logic              r1_neg;

    always_ff @(posedge i_clk) begin
        r1_mag <= r0_abs + K_NW'(r0_den >> 1);
        r1_den <= r0_den;
        r1_neg <= r0_neg;
    end

    // D2 feeds the bit stages; quotients beyond K_QW bits saturate anyway
    logic [K_NW-1:0]   r_rem [K_QW+1];
    logic [K_QW-1:0]   r_q   [K_QW+1];
    logic [K_DENW-1:0] r_den [K_QW+1];
    logic              r_neg [K_QW+1];
    logic              r_sat [K_QW+1];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= r1_mag;
        r_q[0]   <= '0;
        r_den[0] <= r1_den;
        r_neg[0] <= r1_neg;
        r_sat[0] <= (r1_mag >= (K_NW'(r1_den) << K_QW));
    end

    for (genvar k = 0; k < K_QW; k++) begin : g_bit
        logic [K_NW-1:0] trial;
        logic            take;

        assign trial = K_NW'(r_den[k]) << (K_QW - 1 - k);
        assign take  = (r_rem[k] >= trial);

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= take ? r_rem[k] - trial : r_rem[k];
            r_q[k+1]   <= {r_q[k][K_QW-2:0], take};
            r_den[k+1] <= r_den[k];
            r_neg[k+1] <= r_neg[k];
            r_sat[k+1] <= r_sat[k];
        end
    end

    // final clamp to the signed 16-bit range
    logic signed [K_CW-1:0] r_quo;
    logic [K_QW-1:0]        q_f;

    assign q_f = r_q[K_QW];

    always_ff @(posedge i_clk) begin
        if (r_neg[K_QW]) begin
            if (r_sat[K_QW] || q_f > K_QMAX_NEG) begin
                r_quo <= K_CW'(K_QW'(0) - K_QMAX_NEG);
            end else begin
                r_quo <= K_CW'(K_QW'(0) - q_f);
            end
        end else begin
            if (r_sat[K_QW] || q_f > K_QMAX_POS) begin
                r_quo <= K_CW'(K_QMAX_POS);
            end else begin
                r_quo <= K_CW'(q_f);
            end
        end
    end

    assign o_quo = r_quo;

endmodule

// ----- rtl/core/tbi_back.sv -----
// Back pipeline: weighted numerators for each axis, division and result assembly.
module tbi_back import tbi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_mid i_mid,
    output logic o_vld,
    output t_out o_result
);
    logic [K_BACK_LAT-1:0] r_vld;
    t_flags                r_flags [K_BACK_LAT];

    logic [K_DENW-1:0] r1_den, r2_den, r3_den;
    logic signed [K_CW-1:0] quo [3];

    // cross products split into a signed high part and an unsigned low part
    logic signed [K_HW:0]        det_lo, nb_lo, nc_lo;
    logic signed [K_XW-K_HW-1:0] det_hi, nb_hi, nc_hi;

    assign det_lo = $signed({1'b0, i_mid.det[K_HW-1:0]});
    assign nb_lo  = $signed({1'b0, i_mid.nb[K_HW-1:0]});
    assign nc_lo  = $signed({1'b0, i_mid.nc[K_HW-1:0]});
    assign det_hi = i_mid.det[K_XW-1:K_HW];
    assign nb_hi  = i_mid.nb[K_XW-1:K_HW];
    assign nc_hi  = i_mid.nc[K_XW-1:K_HW];

    always_ff @(posedge i_clk) begin
        r1_den <= i_mid.det[K_DENW-1:0];
        r2_den <= r1_den;
        r3_den <= r2_den;
    end

    for (genvar g = 0; g < 3; g++) begin : g_axis
        logic signed [K_MW-1:0] r1_alo, r1_ahi, r1_blo, r1_bhi, r1_clo, r1_chi;
        logic signed [K_NW-1:0] r2_ta, r2_tb, r2_tc, r3_num;

        // B1: partial products
        always_ff @(posedge i_clk) begin
            r1_alo <= K_MW'(i_mid.crd[g].a)  * K_MW'(det_lo);
            r1_ahi <= K_MW'(i_mid.crd[g].a)  * K_MW'(det_hi);
            r1_blo <= K_MW'(i_mid.crd[g].ba) * K_MW'(nb_lo);
            r1_bhi <= K_MW'(i_mid.crd[g].ba) * K_MW'(nb_hi);
            r1_clo <= K_MW'(i_mid.crd[g].ca) * K_MW'(nc_lo);
            r1_chi <= K_MW'(i_mid.crd[g].ca) * K_MW'(nc_hi);
        end

        // B2: recombine halves
        always_ff @(posedge i_clk) begin
            r2_ta <= (K_NW'(r1_ahi) <<< K_HW) + K_NW'(r1_alo);
            r2_tb <= (K_NW'(r1_bhi) <<< K_HW) + K_NW'(r1_blo);
            r2_tc <= (K_NW'(r1_chi) <<< K_HW) + K_NW'(r1_clo);
        end

        // B3: a*det + nb*(b-a) + nc*(c-a)
        always_ff @(posedge i_clk) begin
            r3_num <= r2_ta + r2_tb + r2_tc;
        end

        tbi_div u_div (
            .i_clk (i_clk),
            .i_num (r3_num),
            .i_den (r3_den),
            .o_quo (quo[g])
        );
    end

    always_ff @(posedge i_clk) begin
        r_flags[0] <= i_mid.flags;
    end

    for (genvar s = 1; s < K_BACK_LAT; s++) begin : g_flags
        always_ff @(posedge i_clk) begin
            r_flags[s] <= r_flags[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[K_BACK_LAT-2:0], i_vld};
        end
    end

    t_flags fl;
    assign fl = r_flags[K_BACK_LAT-1];

    always_comb begin
        o_result.inside_res = fl.in_tri;
        o_result.degenerate = fl.degenerate;
        o_result.surface_x  = fl.degenerate ? '0 : quo[0];
        o_result.surface_y  = fl.degenerate ? '0 : quo[1];
        o_result.surface_z  = fl.degenerate ? '0 : quo[2];
    end

    assign o_vld = r_vld[K_BACK_LAT-1];

endmodule

// ----- rtl/core/triangle_barycentric_test_interp_top.sv -----
// Top level: point-in-triangle test with barycentric interpolation.
// A result passes through 5 front pipeline stages (the first taken at the accepting
// edge), the middle queue, 24 back stages (3 multiply/sum stages plus the 21-stage
// divider) and the output queue before it shows at the head of the output queue.
// Throughput is one item per cycle until credits on the middle queue (MID_DEPTH) or
// the output queue (OUT_DEPTH) run out and hold items back. Reset empties both queues
// and all pipeline valid bits; payload registers are not cleared.
module triangle_barycentric_test_interp_top import tbi_pkg::*; #(
    parameter int MID_DEPTH = 8,
    parameter int OUT_DEPTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic empty,
    input  logic pop,
    output t_out o_result
);
    localparam int FCW = $clog2(MID_DEPTH + 1);
    localparam int BCW = $clog2(OUT_DEPTH + 1);

    logic [FCW-1:0] r_front_cnt, n_front_cnt;
    logic [BCW-1:0] r_back_cnt, n_back_cnt;

    logic in_acc, out_acc, mid_pop, mid_empty;
    logic front_vld, back_vld;
    t_mid front_mid, mid_rdata;
    t_out back_res;

    assign full    = (r_front_cnt == FCW'(MID_DEPTH));
    assign in_acc  = push && !full;
    assign out_acc = pop && !empty;
    assign mid_pop = !mid_empty && (r_back_cnt < BCW'(OUT_DEPTH));

    // credits count items in flight plus items queued behind each pipeline
    always_comb begin
        n_front_cnt = r_front_cnt;
        n_back_cnt  = r_back_cnt;
        if (in_acc && !mid_pop) begin
            n_front_cnt = r_front_cnt + 1'b1;
        end else if (!in_acc && mid_pop) begin
            n_front_cnt = r_front_cnt - 1'b1;
        end
        if (mid_pop && !out_acc) begin
            n_back_cnt = r_back_cnt + 1'b1;
        end else if (!mid_pop && out_acc) begin
            n_back_cnt = r_back_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_cnt <= '0;
            r_back_cnt  <= '0;
        end else begin
            r_front_cnt <= n_front_cnt;
            r_back_cnt  <= n_back_cnt;
        end
    end

    tbi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (in_acc),
        .i_item  (i_item),
        .o_vld   (front_vld),
        .o_mid   (front_mid)
    );

    tbi_fifo #(
        .WIDTH ($bits(t_mid)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_vld),
        .i_wdata (front_mid),
        .i_rd    (mid_pop),
        .o_rdata (mid_rdata),
        .o_empty (mid_empty)
    );

    tbi_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (mid_pop),
        .i_mid    (mid_rdata),
        .o_vld    (back_vld),
        .o_result (back_res)
    );

    tbi_fifo #(
        .WIDTH ($bits(t_out)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (back_vld),
        .i_wdata (back_res),
        .i_rd    (out_acc),
        .o_rdata (o_result),
        .o_empty (empty)
    );

endmodule
